FILE: design/gdnc_pkg.sv
// ----------------------------------------------------------------------------
// gdnc_pkg: Gregorian date / Julian day number converter package
// Beat types, calendar constants and small month tables.
// ----------------------------------------------------------------------------
package gdnc_pkg;

  typedef enum logic {
    ReqDateToJdn = 1'b0,
    ReqJdnToDate = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] day_number;
  } req_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [22:0] day_number_out;
  } res_t;

  localparam logic [22:0] JdnMin     = 23'd1721426;
  localparam logic [22:0] JdnMax     = 23'd5373484;
  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [22:0] JdnOffset  = 23'd32044;
  localparam logic [23:0] JdnBase    = 24'd32045;
  localparam logic [14:0] EpochYear  = 15'd4800;
  localparam logic [25:0] DaysPer400 = 26'd146097;
  localparam logic [17:0] DaysPer4   = 18'd1461;

  // floor(x / d) = (x * Mul) >> Shift, exact or low by one over the used range
  localparam logic [12:0] Div100Mul  = 13'd5243;   // shift 19
  localparam logic [14:0] Div400yMul = 15'd29398;  // shift 32
  localparam logic [13:0] Div4yMul   = 14'd11483;  // shift 24
  localparam logic [12:0] Div153Mul  = 13'd6854;   // shift 20

  // days from March 1 to the first of month offset m (March = 0)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    case (mo) inside
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: design/gregorian_day_number_convert.sv
// ----------------------------------------------------------------------------
// gregorian_day_number_convert: Gregorian date <-> Julian day number
// Eight-stage pipeline converting each beat in the direction it requests.
// ----------------------------------------------------------------------------
// Each input beat gives one result beat, in order. A new beat can be taken
// every cycle unless a full pipeline stalls. Each stage holds one valid bit
// and moves whenever it is empty or the stage after it moves, so bubbles
// close up and the input stays ready while a finished result waits on the
// output as long as some stage is empty. The depth is set by the day number
// to date path: three reciprocal multiplications, the first two followed by
// a stage of correct-and-subtract and the last by the final subtract that
// assembles the date. Invalid requests return valid_res low and zero fields.
module gregorian_day_number_convert
  import gdnc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  localparam int unsigned NStages = 8;

  typedef struct packed {
    logic        req;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] day_number;
    // date to day number
    logic        fval;
    logic [14:0] yshift;
    logic [3:0]  mofs;
    logic [26:0] py;
    logic [26:0] pyr;
    logic [7:0]  qy;
    logic [22:0] t1;
    logic [8:0]  mdy;
    logic [22:0] jd;
    // day number to date
    logic        ival;
    logic [22:0] ia;
    logic [24:0] x1;
    logic [39:0] p1;
    logic [7:0]  b;
    logic [25:0] bm;
    logic [15:0] c;
    logic [17:0] x2;
    logic [31:0] p2;
    logic [6:0]  d;
    logic [17:0] dm;
    logic [8:0]  e;
    logic [23:0] p3;
    res_t        res;
  } pipe_t;

  pipe_t              st_d [1:NStages];
  pipe_t              st_q [1:NStages];
  logic [NStages:1]   v_q;
  logic [NStages:1]   en;
  logic [NStages:1]   v_in;

  always_comb begin
    en[NStages] = !v_q[NStages] || out_ready_i;
    for (int k = NStages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NStages-1:1], in_valid_i};

  always_comb begin
    logic        am;
    logic [13:0] yr_rem;
    logic        leap;
    logic [25:0] r1;
    logic        c1;
    logic [17:0] r2;
    logic        c2;
    logic [3:0]  mm;
    logic        hi;
    logic [15:0] ysum;

    // stage 1: shift the year to March-based, start reciprocal products
    st_d[1]            = '0;
    st_d[1].req        = in_data_i.req_type;
    st_d[1].year       = in_data_i.year;
    st_d[1].month      = in_data_i.month;
    st_d[1].day        = in_data_i.day;
    st_d[1].day_number = in_data_i.day_number;
    am                 = (in_data_i.month < 4'd3);
    st_d[1].fval       = (in_data_i.year != '0) && (in_data_i.year <= YearMax) &&
                         (in_data_i.month != '0) && (in_data_i.month <= 4'd12) &&
                         (in_data_i.day != '0);
    st_d[1].yshift     = 15'(in_data_i.year) + EpochYear - 15'(am);
    st_d[1].mofs       = am ? in_data_i.month + 4'd9 : in_data_i.month - 4'd3;
    st_d[1].py         = 27'(st_d[1].yshift) * 27'(Div100Mul);
    st_d[1].pyr        = 27'(in_data_i.year) * 27'(Div100Mul);
    st_d[1].ival       = (in_data_i.day_number >= JdnMin) &&
                         (in_data_i.day_number <= JdnMax);
    st_d[1].ia         = in_data_i.day_number + JdnOffset;
    st_d[1].x1         = {st_d[1].ia, 2'b11};
    st_d[1].p1         = 40'(st_d[1].x1) * 40'(Div400yMul);

    // stage 2: leap check, day bound, partial sums; 400-year product
    st_d[2]      = st_q[1];
    st_d[2].qy   = st_q[1].py[26:19];
    yr_rem       = st_q[1].year - 14'(16'(st_q[1].pyr[26:19]) * 16'd100);
    leap         = (st_q[1].year[1:0] == 2'b00) &&
                   ((yr_rem != '0) || (st_q[1].pyr[20:19] == 2'b00));
    st_d[2].fval = st_q[1].fval && (st_q[1].day <= month_days(st_q[1].month, leap));
    st_d[2].t1   = 23'(st_q[1].yshift) * 23'd365 + 23'(st_q[1].yshift >> 2);
    st_d[2].mdy  = days_before(st_q[1].mofs) + 9'(st_q[1].day);
    st_d[2].b    = st_q[1].p1[39:32];
    st_d[2].bm   = 26'(st_d[2].b) * DaysPer400;

    // stage 3: day number sum; 400-year quotient fix, day in cycle
    st_d[3]    = st_q[2];
    st_d[3].jd = 23'(24'(st_q[2].t1) + 24'(st_q[2].mdy) + 24'(st_q[2].qy >> 2)
                     - 24'(st_q[2].qy) - JdnBase);
    r1         = 26'(st_q[2].x1) - st_q[2].bm;
    c1         = (r1 >= DaysPer400);
    st_d[3].b  = st_q[2].b + 8'(c1);
    st_d[3].c  = 16'(26'(st_q[2].ia) -
                     ((st_q[2].bm + (c1 ? DaysPer400 : 26'd0)) >> 2));

    // stage 4: 4-year product
    st_d[4]    = st_q[3];
    st_d[4].x2 = {st_q[3].c, 2'b11};
    st_d[4].p2 = 32'(st_d[4].x2) * 32'(Div4yMul);

    // stage 5: 4-year quotient estimate
    st_d[5]    = st_q[4];
    st_d[5].d  = st_q[4].p2[30:24];
    st_d[5].dm = 18'(st_d[5].d) * DaysPer4;

    // stage 6: quotient fix, day of March-based year
    st_d[6]   = st_q[5];
    r2        = st_q[5].x2 - st_q[5].dm;
    c2        = (r2 >= DaysPer4);
    st_d[6].d = st_q[5].d + 7'(c2);
    st_d[6].e = 9'(16'(st_q[5].c) -
                   16'((19'(st_q[5].dm) + (c2 ? 19'(DaysPer4) : 19'd0)) >> 2));

    // stage 7: month product
    st_d[7]    = st_q[6];
    st_d[7].p3 = 24'(11'(12'(st_q[6].e) * 12'd5 + 12'd2)) * 24'(Div153Mul);

    // stage 8: assemble the result
    st_d[8] = st_q[7];
    mm      = st_q[7].p3[23:20];
    hi      = (mm >= 4'd10);
    ysum    = 16'(st_q[7].b) * 16'd100 + 16'(st_q[7].d) + 16'(hi) - 16'(EpochYear);
    st_d[8].res = '0;
    if (st_q[7].req == ReqJdnToDate) begin
      if (st_q[7].ival) begin
        st_d[8].res.valid_res      = 1'b1;
        st_d[8].res.year_out       = 14'(ysum);
        st_d[8].res.month_out      = hi ? mm - 4'd9 : mm + 4'd3;
        st_d[8].res.day_out        = 5'(st_q[7].e - days_before(mm) + 9'd1);
        st_d[8].res.day_number_out = st_q[7].day_number;
      end
    end else begin
      if (st_q[7].fval) begin
        st_d[8].res.valid_res      = 1'b1;
        st_d[8].res.year_out       = st_q[7].year;
        st_d[8].res.month_out      = st_q[7].month;
        st_d[8].res.day_out        = st_q[7].day;
        st_d[8].res.day_number_out = st_q[7].jd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NStages; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NStages];
  assign out_data_o  = st_q[NStages].res;

endmodule

FILE: bench/gregorian_day_number_convert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_day_number_convert_test: date / day number converter bench
// Drives dates and day numbers in both directions, with bursty input and a
// stalling output. Each result beat is checked field by field against an
// in-order queue of predicted conversions.
// ----------------------------------------------------------------------------

import gdnc_pkg::*;

function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
  bit leap;
  leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  if (m == 4 || m == 6 || m == 9 || m == 11) begin
    return 30;
  end
  if (m == 2) begin
    return leap ? 29 : 28;
  end
  return 31;
endfunction

class convert_checker;
  res_t        pending_results[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  function res_t calendar_convert(req_t rq);
    res_t        r;
    int unsigned yr, mo, dy, jd;
    int unsigned a, b, c, d, e, m, y;
    r = '0;
    if (rq.req_type == ReqDateToJdn) begin
      yr = rq.year;
      mo = rq.month;
      dy = rq.day;
      if (yr >= 1 && yr <= YearMax && mo >= 1 && mo <= 12 && dy >= 1 &&
          dy <= days_in_month(yr, mo)) begin
        a  = (14 - mo) / 12;
        y  = yr + 4800 - a;
        m  = mo + 12 * a - 3;
        jd = dy + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
        r.valid_res      = 1'b1;
        r.year_out       = 14'(yr);
        r.month_out      = 4'(mo);
        r.day_out        = 5'(dy);
        r.day_number_out = 23'(jd);
      end
    end else begin
      jd = rq.day_number;
      if (jd >= JdnMin && jd <= JdnMax) begin
        a = jd + 32044;
        b = (4 * a + 3) / 146097;
        c = a - (b * 146097) / 4;
        d = (4 * c + 3) / 1461;
        e = c - (1461 * d) / 4;
        m = (5 * e + 2) / 153;
        r.valid_res      = 1'b1;
        r.year_out       = 14'(b * 100 + d + m / 10 - 4800);
        r.month_out      = 4'(m + 3 - 12 * (m / 10));
        r.day_out        = 5'(e - (153 * m + 2) / 5 + 1);
        r.day_number_out = 23'(jd);
      end
    end
    return r;
  endfunction

  function void note_request(req_t rq);
    pending_results.push_back(calendar_convert(rq));
  endfunction

  task report(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result beat with nothing pending: %p", got));
      return;
    end
    want = pending_results.pop_front();
    check_field("valid_res", got.valid_res, want.valid_res);
    check_field("year_out", got.year_out, want.year_out);
    check_field("month_out", got.month_out, want.month_out);
    check_field("day_out", got.day_out, want.day_out);
    check_field("day_number_out", got.day_number_out, want.day_number_out);
  endtask
endclass

module gregorian_day_number_convert_test;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned IdleLimit   = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_data_o;

  convert_checker board = new();
  int unsigned    idle_cycles = 0;
  int unsigned    stall_count = 0;
  int unsigned    stall_mode  = 0;

  gregorian_day_number_convert u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always #10 clk_i = ~clk_i;

  function automatic req_t date_req(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    req_t rq;
    rq.req_type   = ReqDateToJdn;
    rq.year       = 14'(y);
    rq.month      = 4'(m);
    rq.day        = 5'(d);
    rq.day_number = 23'($urandom());
    return rq;
  endfunction

  function automatic req_t jdn_req(input int unsigned jd);
    req_t rq;
    rq.req_type   = ReqJdnToDate;
    rq.year       = 14'($urandom());
    rq.month      = 4'($urandom());
    rq.day        = 5'($urandom());
    rq.day_number = 23'(jd);
    return rq;
  endfunction

  function automatic req_t random_request();
    req_t        rq;
    int unsigned pick, y, m, len;
    rq.req_type   = 1'($urandom());
    rq.year       = 14'($urandom());
    rq.month      = 4'($urandom());
    rq.day        = 5'($urandom());
    rq.day_number = 23'($urandom());
    pick = $urandom_range(0, 9);
    if (pick == 1) begin
      rq.req_type = ReqJdnToDate;
    end else if (pick >= 2 && pick <= 5) begin
      y = ($urandom_range(0, 3) == 0) ? 4 * $urandom_range(1, 2499) : $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      len = days_in_month(y, m);
      rq = date_req(y, m, ($urandom_range(0, 3) == 0) ? len + $urandom_range(0, 1)
                                                      : $urandom_range(1, len));
    end else if (pick >= 6) begin
      case ($urandom_range(0, 7))
        0:       rq = jdn_req(JdnMin + $urandom_range(0, 800));
        1:       rq = jdn_req(JdnMax - $urandom_range(0, 800));
        default: rq = jdn_req($urandom_range(JdnMin, JdnMax));
      endcase
    end
    return rq;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input req_t rq);
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // receiver stall pattern, whose mode is reshuffled at random by stall_count
  always @(negedge clk_i) begin
    stall_count++;
    if (stall_count % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom());
      2:       out_ready_i <= (stall_count % 4 == 0);
      default: out_ready_i <= (stall_count % 32 >= 8);
    endcase
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      board.note_request(in_data_i);
    end
    if (out_valid_o && out_ready_i) begin
      board.check_result(out_data_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_t        directed[$];
    int unsigned sent, burst, gap;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{date_req(1, 1, 1), date_req(9999, 12, 31), date_req(0, 1, 1),
                 date_req(10000, 1, 1), date_req(16383, 15, 31), date_req(2000, 2, 29),
                 date_req(1900, 2, 29), date_req(1900, 2, 28), date_req(2004, 2, 29),
                 date_req(2001, 2, 29), date_req(2023, 4, 31), date_req(2023, 4, 30),
                 date_req(2023, 0, 10), date_req(2023, 13, 10), date_req(2023, 5, 0),
                 date_req(2023, 7, 31), jdn_req(0), jdn_req(JdnMin - 1), jdn_req(JdnMin),
                 jdn_req(JdnMax), jdn_req(JdnMax + 1), jdn_req(23'h7FFFFF),
                 jdn_req(2451545), jdn_req(2299161)};
    foreach (directed[i]) begin
      send_request(directed[i]);
    end

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_request(random_request());
      end
      sent += burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
